// ===== hw/rtl/srtn_pkg.sv =====
// shared constants and types of the shortest-remaining-time-next scheduler
`timescale 1ns / 1ps

package srtn_pkg;

	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int PICK_W    = IDX_W + 1;
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int ARR_W     = 16;
	localparam int DUR_W     = 12;
	localparam int TIME_W    = 16;
	localparam int SW_W      = 16;
	localparam int RUN_W     = 4;
	localparam int IN_W      = 32;
	localparam int OUT_W     = 72;

	localparam logic [PICK_W-1:0] IDLE_CODE = PICK_W'(MAX_PROCS);
	localparam logic [TIME_W-1:0] TIME_MAX  = '1;
	localparam logic [SW_W-1:0]   SW_MAX    = '1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic [ARR_W-1:0] arrival;
		logic [DUR_W-1:0] run_length;
		logic [DUR_W-1:0] time_left;
	} entry_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		logic             done;
		entry_t           entry;
	} cand_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		entry_t           entry;
	} best_t;

	typedef struct packed {
		logic              all_done;
		logic [SW_W-1:0]   switch_total;
		logic [TIME_W-1:0] waiting;
		logic [TIME_W-1:0] lifetime;
		logic              finished;
		logic              context_switch;
		logic              idle;
		logic [RUN_W-1:0]  run_index;
		logic [TIME_W-1:0] time_slot;
	} res_t;

endpackage

// ===== hw/rtl/srtn_process_scheduler_top.sv =====
// top level of the shortest-remaining-time-next process scheduler
// usage:
//   items enter on the s_ group; s_tuser selects load (0) or tick (1),
//   s_tdata carries arrival and duration. a load appends one process to
//   the table and gives no result; loads after the first tick or into a
//   full table are dropped.
//   a tick gives one result transfer on the m_ group. the tick streams the
//   loaded entries out of the table memory one per cycle into the minimum
//   tracker, then writes the picked entry back and fills the result
//   register in the same step. the next item is taken the cycle after
//   write-back; no new item, load or tick, is taken while a tick is in
//   progress.
//   the result sits in an output register: while it waits, s_tready is
//   high again and further loads are taken; a following tick is held in
//   its write-back step until the output register is free.
//   reset clears the counters, the done marks, time and the previous pick;
//   table contents need no clearing and the block is ready at once.
`timescale 1ns / 1ps

module srtn_process_scheduler_top
	import srtn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // arrival, duration, zero pad
	input  logic [0:0]       s_tuser,  // cmd
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // time_slot, run_index, idle, context_switch,
	                                   // finished, lifetime, waiting, switch_total, all_done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     pc_q;
	logic [CNT_W-1:0]     cnt_done_q;
	logic [TIME_W-1:0]    time_q;
	logic [PICK_W-1:0]    prev_q;
	logic [SW_W-1:0]      sw_cnt_q;
	logic                 started_q;
	logic [MAX_PROCS-1:0] done_q;
	logic [CNT_W-1:0]     iss_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	entry_t               rd_data_s1;
	logic                 out_vld_q;
	res_t                 out_q;

	entry_t mem [MAX_PROCS];

	logic [ARR_W-1:0]  in_arrival;
	logic [DUR_W-1:0]  in_duration;
	logic              accept;
	logic              load_ok;
	logic              tick_go;
	logic              rd_en;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	cand_t             cand;
	best_t             best;
	logic              out_free;
	logic              out_load;
	logic [DUR_W-1:0]  tl_next;
	logic              fin;
	logic [PICK_W-1:0] pick_code;
	logic              sw;
	logic [SW_W-1:0]   sw_next;
	logic [CNT_W-1:0]  done_next;
	logic [TIME_W:0]   life_wide;
	logic [TIME_W-1:0] life;
	logic [TIME_W-1:0] run_ext;
	res_t              res;

	assign in_arrival  = s_tdata[ARR_W-1:0];
	assign in_duration = s_tdata[ARR_W+DUR_W-1:ARR_W];
	assign s_tready    = (state_q == S_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign load_ok     = accept && (s_tuser[0] == CMD_LOAD) && !started_q
		&& (pc_q < CNT_W'(MAX_PROCS));
	assign tick_go     = accept && (s_tuser[0] == CMD_TICK);
	assign rd_en       = (state_q == S_SCAN) && (iss_q < pc_q);
	assign out_free    = !out_vld_q || m_tready;
	assign out_load    = (state_q == S_UPD) && out_free;

	always_comb begin
		cand.vld   = rd_vld_s1;
		cand.idx   = rd_idx_s1;
		cand.done  = done_q[rd_idx_s1];
		cand.entry = rd_data_s1;
	end

	srtn_pick u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (tick_go),
		.cand     (cand),
		.time_now (time_q),
		.best     (best)
	);

	// write-back of the picked entry and result fields
	always_comb begin
		tl_next   = best.entry.time_left - DUR_W'(1);
		fin       = best.found && (tl_next == '0);
		pick_code = best.found ? {1'b0, best.idx} : IDLE_CODE;
		sw        = (pick_code != prev_q);
		sw_next   = (sw && (sw_cnt_q != SW_MAX)) ? sw_cnt_q + SW_W'(1) : sw_cnt_q;
		done_next = fin ? cnt_done_q + CNT_W'(1) : cnt_done_q;
		life_wide = {1'b0, time_q} + (TIME_W+1)'(1) - {1'b0, best.entry.arrival};
		life      = life_wide[TIME_W] ? TIME_MAX : life_wide[TIME_W-1:0];
		run_ext   = TIME_W'(best.entry.run_length);

		res.time_slot      = time_q;
		res.run_index      = best.found ? RUN_W'(best.idx) : '0;
		res.idle           = !best.found;
		res.context_switch = sw;
		res.finished       = fin;
		res.lifetime       = fin ? life : '0;
		res.waiting        = (fin && (life > run_ext)) ? life - run_ext : '0;
		res.switch_total   = sw_next;
		res.all_done       = (done_next == pc_q);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pc_q[IDX_W-1:0];
		wr_data = '{arrival: in_arrival, run_length: in_duration, time_left: in_duration};
		if (load_ok) begin
			wr_en = 1'b1;
		end else if (out_load && best.found) begin
			wr_en   = 1'b1;
			wr_addr = best.idx;
			wr_data = '{arrival: best.entry.arrival, run_length: best.entry.run_length,
				time_left: tl_next};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[iss_q[IDX_W-1:0]];
		rd_idx_s1  <= iss_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= '0;
			cnt_done_q <= '0;
			time_q     <= '0;
			prev_q     <= IDLE_CODE;
			sw_cnt_q   <= '0;
			started_q  <= 1'b0;
			done_q     <= '0;
			iss_q      <= '0;
			rd_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (load_ok) begin
						done_q[pc_q[IDX_W-1:0]] <= (in_duration == '0);
						if (in_duration == '0) begin
							cnt_done_q <= cnt_done_q + CNT_W'(1);
						end
						pc_q <= pc_q + CNT_W'(1);
					end
					if (tick_go) begin
						started_q <= 1'b1;
						iss_q     <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						iss_q <= iss_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (out_load) begin
						if (fin) begin
							done_q[best.idx] <= 1'b1;
						end
						cnt_done_q <= done_next;
						sw_cnt_q   <= sw_next;
						prev_q     <= pick_code;
						if (time_q != TIME_MAX) begin
							time_q <= time_q + TIME_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_done_q <= pc_q)
		else $error("completed count above process count");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !wr_en)
		else $error("table write during scan");

	a_started_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("started flag cleared");

	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (state_q == S_IDLE) && m_tvalid)
		else $error("result transfer not presented after write-back");
`endif

endmodule

// ===== hw/rtl/srtn_pick.sv =====
// running minimum over the table entries streamed out of the memory
`timescale 1ns / 1ps

module srtn_pick
	import srtn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  cand_t             cand,
	input  logic [TIME_W-1:0] time_now,
	output best_t             best
);

	logic             found_q;
	logic [IDX_W-1:0] idx_q;
	entry_t           entry_q;
	logic             elig;
	logic             better;

	always_comb begin
		elig   = cand.vld && !cand.done && (cand.entry.arrival <= time_now);
		better = !found_q
			|| (cand.entry.time_left < entry_q.time_left)
			|| ((cand.entry.time_left == entry_q.time_left)
				&& (cand.entry.arrival < entry_q.arrival));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (elig && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clr && elig && better) begin
			idx_q   <= cand.idx;
			entry_q <= cand.entry;
		end
	end

	assign best = '{found: found_q, idx: idx_q, entry: entry_q};

endmodule

// ===== tb/srtn_schedule_checker.sv =====
// checker that predicts every tick of the scheduler and compares its result transfers
`timescale 1ns / 1ps

module srtn_schedule_checker
	import srtn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // arrival, duration, zero pad
	input  logic [0:0]       s_tuser,  // cmd
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,  // time_slot, run_index, idle, context_switch,
	                                   // finished, lifetime, waiting, switch_total, all_done
	output int               failures,
	output int               pending_results
);

	logic [ARR_W-1:0]  arr_tab  [MAX_PROCS];
	logic [DUR_W-1:0]  len_tab  [MAX_PROCS];
	logic [DUR_W-1:0]  left_tab [MAX_PROCS];
	logic              done_tab [MAX_PROCS];
	logic [CNT_W-1:0]  n_loaded;
	logic [CNT_W-1:0]  n_completed;
	logic [TIME_W-1:0] now;
	logic [PICK_W-1:0] last_pick;
	logic [SW_W-1:0]   n_switches;
	logic              ticking;
	res_t              expected_slots [$];
	int                mismatches;

	task automatic clear_schedule();
		for (int i = 0; i < MAX_PROCS; i++) begin
			arr_tab[i]  = '0;
			len_tab[i]  = '0;
			left_tab[i] = '0;
			done_tab[i] = 1'b0;
		end
		n_loaded    = '0;
		n_completed = '0;
		now         = '0;
		last_pick   = IDLE_CODE;
		n_switches  = '0;
		ticking     = 1'b0;
		mismatches  = 0;
		expected_slots.delete();
	endtask

	task automatic record_load(input logic [ARR_W-1:0] arr, input logic [DUR_W-1:0] dur);
		int slot;
		slot = int'(n_loaded);
		if (!ticking && slot < MAX_PROCS) begin
			arr_tab[slot]  = arr;
			len_tab[slot]  = dur;
			left_tab[slot] = dur;
			done_tab[slot] = 1'b0;
			// an empty job is complete the moment it is loaded
			if (dur == '0) begin
				done_tab[slot] = 1'b1;
				n_completed++;
			end
			n_loaded++;
		end
	endtask

	task automatic predict_tick(output res_t r);
		int best;
		logic [PICK_W-1:0] pick;
		logic [TIME_W:0]   life;
		best = -1;
		for (int i = 0; i < MAX_PROCS; i++) begin
			if (i < int'(n_loaded) && !done_tab[i] && arr_tab[i] <= now) begin
				if (best < 0 || left_tab[i] < left_tab[best] ||
				    (left_tab[i] == left_tab[best] && arr_tab[i] < arr_tab[best]))
					best = i;
			end
		end
		pick    = (best < 0) ? IDLE_CODE : PICK_W'(best);
		ticking = 1'b1;
		r = '0;
		r.time_slot      = now;
		r.idle           = (best < 0);
		r.context_switch = (pick != last_pick);
		if (r.context_switch && n_switches != SW_MAX)
			n_switches++;
		last_pick = pick;
		if (best >= 0) begin
			r.run_index    = RUN_W'(best);
			left_tab[best] = left_tab[best] - 1'b1;
			if (left_tab[best] == '0) begin
				r.finished     = 1'b1;
				done_tab[best] = 1'b1;
				n_completed++;
				life = {1'b0, now} + 1'b1 - {1'b0, arr_tab[best]};
				r.lifetime = (life > {1'b0, TIME_MAX}) ? TIME_MAX : life[TIME_W-1:0];
				r.waiting  = (r.lifetime > TIME_W'(len_tab[best])) ?
				             r.lifetime - TIME_W'(len_tab[best]) : '0;
			end
		end
		if (now != TIME_MAX)
			now++;
		r.switch_total = n_switches;
		r.all_done     = (n_completed == n_loaded);
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] want,
	                           input logic [TIME_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t got;
		res_t want;
		if (!arst_n) begin
			clear_schedule();
			failures        <= 0;
			pending_results <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata);
				if (expected_slots.size() == 0) begin
					$display("%0t: result with none expected, got %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = expected_slots.pop_front();
					check_field("time_slot", want.time_slot, got.time_slot);
					check_field("run_index", TIME_W'(want.run_index),
					            TIME_W'(got.run_index));
					check_field("idle", TIME_W'(want.idle), TIME_W'(got.idle));
					check_field("context_switch", TIME_W'(want.context_switch),
					            TIME_W'(got.context_switch));
					check_field("finished", TIME_W'(want.finished),
					            TIME_W'(got.finished));
					check_field("lifetime", want.lifetime, got.lifetime);
					check_field("waiting", want.waiting, got.waiting);
					check_field("switch_total", want.switch_total, got.switch_total);
					check_field("all_done", TIME_W'(want.all_done),
					            TIME_W'(got.all_done));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_TICK) begin
					predict_tick(want);
					expected_slots.push_back(want);
				end else begin
					record_load(s_tdata[ARR_W-1:0], s_tdata[ARR_W +: DUR_W]);
				end
			end
			failures        <= mismatches;
			pending_results <= expected_slots.size();
		end
	end

endmodule

// ===== tb/tb_srtn_process_scheduler_top.sv =====
// testbench top of the scheduler: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_srtn_process_scheduler_top;
	import srtn_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_TICKS = 1500;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;  // arrival, duration, zero pad
	logic [0:0]       s_tuser  = CMD_LOAD;  // cmd
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;  // time_slot, run_index, idle, context_switch,
	                            // finished, lifetime, waiting, switch_total, all_done
	int               failures;
	int               pending_results;
	int               quiet_cycles = 0;
	int               stall_left   = 0;
	bit               calm         = 1'b0;

	always #2 clk = ~clk;

	srtn_process_scheduler_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	srtn_schedule_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.failures        (failures),
		.pending_results (pending_results)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send(input logic cmd, input logic [ARR_W-1:0] arr,
	                    input logic [DUR_W-1:0] dur);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(IN_W - ARR_W - DUR_W){1'b0}}, dur, arr};
		do @(posedge clk); while (!s_tready);
	endtask

	always @(posedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < 30)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
				                                            $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int counted;
		logic [ARR_W-1:0] arr;
		logic [DUR_W-1:0] dur;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// equal length and arrival, so the lower index wins
		send(CMD_LOAD, 16'd5, 12'd1);
		send(CMD_LOAD, 16'd0, 12'd0);
		send(CMD_LOAD, 16'd5, 12'd1);
		// only runs once time has pinned at its maximum
		send(CMD_LOAD, TIME_MAX, 12'd3);
		send(CMD_LOAD, 16'd3, 12'hFFF);
		// shorter remaining time beats the earlier arrival
		send(CMD_LOAD, 16'd7, 12'd2);
		send(CMD_LOAD, 16'd6, 12'd3);
		arr = 16'd8;
		dur = 12'd4;
		for (int i = 7; i < MAX_PROCS; i++) begin
			if ($urandom_range(0, 99) >= 25)
				arr = ARR_W'($urandom_range(8, 900));
			if ($urandom_range(0, 99) >= 35)
				dur = DUR_W'($urandom_range(1, 60));
			send(CMD_LOAD, arr, dur);
		end
		// table full
		send(CMD_LOAD, TIME_MAX, 12'hFFF);
		send(CMD_LOAD, 16'd0, 12'd0);
		repeat (8) send(CMD_TICK, ARR_W'($urandom), DUR_W'($urandom));
		// too late, scheduling has begun
		send(CMD_LOAD, 16'd1, 12'd1);

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);

		counted = 0;
		while (counted < RANDOM_TICKS) begin
			if (counted % 64 == 0)
				calm <= ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 8) begin
				send(CMD_LOAD, ARR_W'($urandom), DUR_W'($urandom));
			end else begin
				send(CMD_TICK, ARR_W'($urandom), DUR_W'($urandom));
				counted++;
			end
		end

		calm     <= 1'b0;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (40) @(posedge clk);
		if (failures == 0 && pending_results == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
